[rtl/dsfp_pkg.sv]
`timescale 1ns / 1ps

package dsfp_pkg;

    // default number of fraction digits in the fixed-point result
    localparam int FRAC_DIGITS_DEF = 8;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int DIGIT_W  = 4;

    // four guard bits hold the carry of value * 10 + digit
    localparam int WIDE_W = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DIGITS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY_FRAC = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO          = 3'd6;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_POINT = 2'd1,
        K_OTHER = 2'd2,
        K_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
    } t_entry;

endpackage

[rtl/dsfp_in_if.sv]
`timescale 1ns / 1ps

interface dsfp_in_if;
    import dsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink (input valid, input char_code, input end_marker, output ready);
endinterface

[rtl/dsfp_out_if.sv]
`timescale 1ns / 1ps

interface dsfp_out_if;
    import dsfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  fixed_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output fixed_value, output status, input ready);
    modport sink (input valid, input fixed_value, input status, output ready);
endinterface

[rtl/dsfp_front.sv]
`timescale 1ns / 1ps

module dsfp_front
    import dsfp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsfp_in_if.sink      i_in,
    output logic         o_q_valid,
    input  logic         i_q_ready,
    output t_entry       o_q_entry
);

    t_entry            w_entry;
    t_entry            r_mem [Q_DEPTH];
    logic [Q_PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count, n_count;
    logic              w_push, w_pop;

    // classify the character
    always_comb begin
        w_entry.digit = DIGIT_W'(i_in.char_code - CH_ZERO);
        if (i_in.end_marker) begin
            w_entry.kind = K_END;
        end else if (i_in.char_code >= CH_ZERO && i_in.char_code <= CH_NINE) begin
            w_entry.kind = K_DIGIT;
        end else if (i_in.char_code == CH_POINT) begin
            w_entry.kind = K_POINT;
        end else begin
            w_entry.kind = K_OTHER;
        end
    end

    assign i_in.ready = (r_count != Q_CW'(Q_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_entry  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

endmodule

[rtl/dsfp_back.sv]
`timescale 1ns / 1ps

module dsfp_back
    import dsfp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    output logic         o_q_ready,
    input  t_entry       i_q_entry,
    dsfp_out_if.source   o_out
);

    localparam int CW = $clog2(FRACTION_DIGITS + 2);
    localparam logic [CW-1:0] FD_C = CW'(FRACTION_DIGITS);

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_SCALE = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_acc, n_acc;
    logic                 r_point, n_point;
    logic                 r_digit, n_digit;
    logic                 r_any, n_any;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [STATUS_W-1:0]  r_err, n_err;

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic [STATUS_W-1:0]  r_out_status;

    logic [WIDE_W-1:0]    w_wide;
    logic [DIGIT_W-1:0]   w_add;
    logic                 w_mul_ovf;
    logic                 w_out_free;
    logic                 w_pop;
    logic                 w_load;
    logic [VALUE_W-1:0]   w_load_value;
    logic [STATUS_W-1:0]  w_load_status;

    // value * 10 + digit, the guard bits flag a 64-bit overflow
    assign w_add     = (r_state == S_RUN) ? i_q_entry.digit : '0;
    assign w_wide    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + WIDE_W'(w_add);
    assign w_mul_ovf = |w_wide[WIDE_W-1:VALUE_W];

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_q_ready  = w_pop;

    always_comb begin
        n_state       = r_state;
        n_acc         = r_acc;
        n_point       = r_point;
        n_digit       = r_digit;
        n_any         = r_any;
        n_cnt         = r_cnt;
        n_err         = r_err;
        w_pop         = 1'b0;
        w_load        = 1'b0;
        w_load_value  = '0;
        w_load_status = ST_OK;
        unique case (r_state)
            S_RUN: begin
                if (i_q_valid) begin
                    unique case (i_q_entry.kind)
                        K_DIGIT: begin
                            w_pop = 1'b1;
                            n_any = 1'b1;
                            if (r_err == ST_OK) begin
                                if (w_mul_ovf) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    n_acc   = w_wide[VALUE_W-1:0];
                                    n_digit = 1'b1;
                                    if (r_point && r_cnt <= FD_C) begin
                                        n_cnt = r_cnt + 1'b1;
                                    end
                                end
                            end
                        end
                        K_POINT: begin
                            w_pop = 1'b1;
                            n_any = 1'b1;
                            if (r_err == ST_OK) begin
                                if (r_point) begin
                                    n_err = ST_BAD_CHAR;
                                end else begin
                                    n_point = 1'b1;
                                end
                            end
                        end
                        K_OTHER: begin
                            w_pop = 1'b1;
                            n_any = 1'b1;
                            if (r_err == ST_OK) begin
                                n_err = ST_BAD_CHAR;
                            end
                        end
                        K_END: begin
                            priority if (!r_any) begin
                                w_load_status = ST_EMPTY;
                            end else if (r_err != ST_OK) begin
                                w_load_status = r_err;
                            end else if (!r_digit) begin
                                w_load_status = ST_NO_DIGITS;
                            end else if (r_cnt > FD_C) begin
                                w_load_status = ST_TOO_MANY_FRAC;
                            end else begin
                                w_load_status = ST_OK;
                            end
                            if (w_load_status == ST_OK) begin
                                // string is clean, go scale it
                                w_pop   = 1'b1;
                                n_state = S_SCALE;
                            end else if (w_out_free) begin
                                w_pop  = 1'b1;
                                w_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SCALE: begin
                if (r_cnt == FD_C) begin
                    if (w_out_free) begin
                        w_load        = 1'b1;
                        w_load_status = (r_acc == '0) ? ST_ZERO : ST_OK;
                        w_load_value  = r_acc;
                        n_state       = S_RUN;
                    end
                end else if (w_mul_ovf) begin
                    if (w_out_free) begin
                        w_load        = 1'b1;
                        w_load_status = ST_OVERFLOW;
                        n_state       = S_RUN;
                    end
                end else begin
                    n_acc = w_wide[VALUE_W-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
        // a delivered result clears the string state
        if (w_load) begin
            n_acc   = '0;
            n_point = 1'b0;
            n_digit = 1'b0;
            n_any   = 1'b0;
            n_cnt   = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_acc       <= '0;
            r_point     <= 1'b0;
            r_digit     <= 1'b0;
            r_any       <= 1'b0;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_point     <= n_point;
            r_digit     <= n_digit;
            r_any       <= n_any;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= w_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value  <= w_load_value;
            r_out_status <= w_load_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fixed_value = r_out_value;
    assign o_out.status      = r_out_status;

endmodule

[rtl/decimal_string_to_fixed_point_top.sv]
`timescale 1ns / 1ps

// channel  | modport           | payload                          | transaction
// ---------+-------------------+----------------------------------+------------------------------
// i_in     | dsfp_in_if.sink   | char_code[7:0], end_marker       | valid && ready at i_clk rise
// o_out    | dsfp_out_if.source| fixed_value[63:0], status[2:0]   | valid && ready at i_clk rise
//
// a character transaction is taken every cycle while i_in is ready, its digit folded in on pop
// an end marker with an early status loads its result directly; a clean string holds the back
//   end while it scales by ten per missing fraction digit, stopping early when scaling overflows
// reset is synchronous, active low, and clears queue, string state and output valid
// a two-entry queue absorbs two transactions while the back end scales or o_out stalls,
//   after that i_in drops ready until the back end pops again

module decimal_string_to_fixed_point_top
    import dsfp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsfp_in_if.sink      i_in,
    dsfp_out_if.source   o_out
);

    // classified characters from front to back
    logic   w_q_valid;
    logic   w_q_ready;
    t_entry w_q_entry;

    // front: classify each character and queue it
    dsfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_entry (w_q_entry)
    );

    // back: accumulate digits, scale at the end marker, hold the result
    dsfp_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_entry (w_q_entry),
        .o_out     (o_out)
    );

    // a full queue must have something to hand to the back end
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_q_valid)
        else $error("queue full but empty");

    // any error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> (o_out.fixed_value == '0))
        else $error("error result with nonzero value");

    // an ok result is never zero
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK) |-> (o_out.fixed_value != '0))
        else $error("ok result with zero value");

    // the back end only pops the queue when it has an entry
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_ready |-> w_q_valid)
        else $error("pop from empty queue");

endmodule

[bench/dsfp_result_checker.sv]
`timescale 1ns / 1ps

module dsfp_result_checker
    import dsfp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dsfp_in_if   i_in_mon,
    dsfp_out_if  i_out_mon,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_compared
);

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } t_conv;

    // string state as it builds up
    logic [VALUE_W-1:0]  acc_value;
    logic                point_taken;
    logic                digit_taken;
    logic                char_taken;
    logic [4:0]          frac_count;
    logic [STATUS_W-1:0] sticky_status;

    t_conv pending_conversions[$];

    function automatic void clear_string();
        acc_value     = '0;
        point_taken   = 1'b0;
        digit_taken   = 1'b0;
        char_taken    = 1'b0;
        frac_count    = '0;
        sticky_status = ST_OK;
    endfunction

    function automatic void fold_char(input logic [CHAR_W-1:0] ch);
        logic [VALUE_W-1:0] digit;
        char_taken = 1'b1;
        // state is frozen once an error has been latched
        if (sticky_status != ST_OK) return;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            digit = VALUE_W'(ch - CH_ZERO);
            if (acc_value > (VALUE_MAX - digit) / 10) begin
                sticky_status = ST_OVERFLOW;
                return;
            end
            acc_value   = acc_value * 10 + digit;
            digit_taken = 1'b1;
            if (point_taken && frac_count <= FRACTION_DIGITS) frac_count++;
        end else if (ch == CH_POINT && !point_taken) begin
            point_taken = 1'b1;
        end else begin
            sticky_status = ST_BAD_CHAR;
        end
    endfunction

    function automatic t_conv conclude_string();
        t_conv              r;
        logic [VALUE_W-1:0] v;
        int                 n;
        r.value  = '0;
        r.status = ST_OK;
        v        = acc_value;
        n        = frac_count;
        if (!char_taken) begin
            r.status = ST_EMPTY;
        end else if (sticky_status != ST_OK) begin
            r.status = sticky_status;
        end else if (!digit_taken) begin
            r.status = ST_NO_DIGITS;
        end else if (n > FRACTION_DIGITS) begin
            r.status = ST_TOO_MANY_FRAC;
        end else begin
            // pad the missing fraction digits
            while (n < FRACTION_DIGITS && r.status == ST_OK) begin
                if (v > VALUE_MAX / 10) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    v = v * 10;
                    n++;
                end
            end
            if (r.status == ST_OK) begin
                if (v == '0) r.status = ST_ZERO;
                else r.value = v;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        o_mismatches++;
        if (o_mismatches <= 40) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_conv want;
        if (!i_rst_n) begin
            clear_string();
            pending_conversions.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.end_marker) begin
                    pending_conversions.push_back(conclude_string());
                    clear_string();
                end else begin
                    fold_char(i_in_mon.char_code);
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_compared++;
                if (pending_conversions.size() == 0) begin
                    report_mismatch("result with no string pending", i_out_mon.fixed_value, '0);
                end else begin
                    want = pending_conversions.pop_front();
                    if (i_out_mon.status !== want.status)
                        report_mismatch("status", VALUE_W'(i_out_mon.status),
                                        VALUE_W'(want.status));
                    if (i_out_mon.fixed_value !== want.value)
                        report_mismatch("fixed value", i_out_mon.fixed_value, want.value);
                end
            end
        end
        o_pending = pending_conversions.size();
    end

endmodule

[bench/decimal_string_to_fixed_point_top_tb.sv]
`timescale 1ns / 1ps

module decimal_string_to_fixed_point_top_tb;
    import dsfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;

    logic clk;
    logic rst_n;

    // per-item idle ceilings for each side, 0 means no idling
    int src_gap_max  = 0;
    int snk_gap_max  = 0;
    // one-shot long stall request for the result side
    int hold_request = 0;

    int chars_sent   = 0;
    int strings_sent = 0;

    int mismatches;
    int pending;
    int compared;

    // characters of the string being assembled
    logic [CHAR_W-1:0] str_buf[$];

    // boundary strings around the 64-bit limit and the fraction width
    string boundary_texts[] = '{
        "18446744073709551615",   // fits while folding, overflows while scaling
        "18446744073709551616",   // overflows on the last digit
        "99999999999999999999",
        "184467440737.09551615",  // largest clean result
        "184467440737.09551616",
        "184467440737",
        "184467440738",           // smallest integer that fails to scale
        "0.00000001",             // smallest nonzero result
        "1.123456789",            // one fraction digit too many
        "0.000000000"             // too many fraction digits wins over zero
    };

    dsfp_in_if  str_ch ();
    dsfp_out_if fix_ch ();

    decimal_string_to_fixed_point_top #(
        .FRACTION_DIGITS(FRAC_DIGITS_DEF)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (str_ch),
        .o_out   (fix_ch)
    );

    // watches both channels, predicts every conversion and compares
    dsfp_result_checker #(
        .FRACTION_DIGITS(FRAC_DIGITS_DEF)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (str_ch),
        .i_out_mon    (fix_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // half the items go straight through, the rest wait up to the ceiling
    function automatic int draw_gap(input int max_gap);
        if (max_gap == 0 || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, max_gap);
    endfunction

    // one input transaction, driven at the falling edge
    task automatic send_item(input logic [CHAR_W-1:0] code, input logic is_end);
        int gap;
        gap = draw_gap(src_gap_max);
        if (gap > 0) begin
            str_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        str_ch.valid      <= 1'b1;
        str_ch.char_code  <= code;
        str_ch.end_marker <= is_end;
        do @(posedge clk); while (!str_ch.ready);
        @(negedge clk);
        if (is_end) strings_sent++;
        else chars_sent++;
    endtask

    // the buffered characters then an end marker carrying a random ignored byte
    task automatic send_buf();
        foreach (str_buf[k]) send_item(str_buf[k], 1'b0);
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        str_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) str_buf.push_back(s[k]);
        send_buf();
    endtask

    function automatic void add_digits(input int n, input bit zeros);
        repeat (n) str_buf.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // any byte at all half of the time, otherwise a point or a digit
    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 3))
            0, 1:    return CHAR_W'($urandom_range(0, 255));
            2:       return CH_POINT;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // well-formed number: short most of the time, now and then long or all zeros
    function automatic void build_number();
        int int_len;
        int frac_len;
        bit zeros;
        zeros   = ($urandom_range(0, 9) == 0);
        int_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        add_digits(int_len, zeros);
        if ($urandom_range(0, 2) != 0) begin
            str_buf.push_back(CH_POINT);
            frac_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11)
                                                   : $urandom_range(0, 8);
            add_digits(frac_len, zeros);
        end
    endfunction

    // prefix of the 64-bit maximum, one low digit sometimes replaced, point placed near the
    // position that leaves exactly the fraction width
    function automatic void build_near_limit();
        string top_text;
        int    len;
        top_text = "18446744073709551615";
        len      = $urandom_range(11, 20);
        for (int k = 0; k < len; k++) str_buf.push_back(top_text[k]);
        if ($urandom_range(0, 1) == 1)
            str_buf[$urandom_range(len - 3, len - 1)] = CH_ZERO + 8'($urandom_range(0, 9));
        if ($urandom_range(0, 3) != 0)
            str_buf.insert($urandom_range(len - 10, len), CH_POINT);
    endfunction

    task automatic send_random_string();
        int pick;
        int pos;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            build_number();
        end else if (pick < 72) begin
            build_near_limit();
        end else if (pick < 86) begin
            // well-formed number with one stray character dropped in
            build_number();
            pos = $urandom_range(0, str_buf.size());
            str_buf.insert(pos, noise_char());
        end else begin
            repeat ($urandom_range(0, 6)) str_buf.push_back(noise_char());
        end
        send_buf();
    endtask

    // result side: random wait before each transaction, or a long hold on request
    initial begin : result_sink
        int hold;
        fix_ch.ready = 1'b0;
        forever begin
            hold = draw_gap(snk_gap_max);
            if (hold_request > 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                fix_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            fix_ch.ready <= 1'b1;
            do @(posedge clk); while (!fix_ch.valid);
            @(negedge clk);
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped after %0d cycles with %0d results outstanding", cycles, pending);
        $display("decimal_string_to_fixed_point_top verification failed");
        $finish;
    end

    initial begin : stimulus
        str_ch.valid      = 1'b0;
        str_ch.char_code  = '0;
        str_ch.end_marker = 1'b0;
        rst_n             = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed strings, back to back
        send_text("");       // end with no characters at all
        send_text("0");      // zero value
        send_text(".");      // point without digits
        send_text("1..");    // second point
        str_buf.push_back(8'hFF);            // bad byte, then a digit that must be ignored
        str_buf.push_back(CH_ZERO + 8'd5);
        send_buf();
        send_text("7.5");
        send_text("0.0");
        send_text(".5");

        foreach (boundary_texts[k]) send_text(boundary_texts[k]);

        // random strings with idling on both sides
        src_gap_max = 19;
        snk_gap_max = 19;
        while (chars_sent + strings_sent < 450) send_random_string();

        // park the result side for a long stretch while strings keep coming,
        // so the internal queue fills and the input stalls
        src_gap_max  = 0;
        hold_request = LONG_HOLD;
        repeat (12) send_text("3");

        // no idling on either side
        snk_gap_max = 0;
        while (chars_sent + strings_sent < 800) send_random_string();

        // sender goes quiet until every conversion is back
        str_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        src_gap_max = 19;
        snk_gap_max = 19;
        while (chars_sent + strings_sent < 1350) send_random_string();
        str_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("drove %0d strings built from %0d character transactions", strings_sent,
                 chars_sent);
        $display("compared %0d conversions at %0d fraction digits, %0d mismatches", compared,
                 FRAC_DIGITS_DEF, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("decimal_string_to_fixed_point_top verification clean");
        end else begin
            $display("decimal_string_to_fixed_point_top verification failed");
        end
        $finish;
    end

endmodule
